// ===== rtl/threshold_edge_detect_3x3_macros.svh =====
// assertion macros for the threshold edge marker
`ifndef THRESHOLD_EDGE_DETECT_3X3_MACROS_SVH
`define THRESHOLD_EDGE_DETECT_3X3_MACROS_SVH

`ifndef SYNTHESIS
`define TED_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("%m: check failed");
`define TED_ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) pre |=> post) \
    else $error("%m: check failed");
`else
`define TED_ASSERT(lbl, ck, rs, prop)
`define TED_ASSERT_NEXT(lbl, ck, rs, pre, post)
`endif

`endif

// ===== rtl/ted_pkg.sv =====
package ted_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS = 256;
  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int SIZE_W = 9;
  localparam int PIX_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [PIX_W-1:0] WHITE = 8'd255;
  localparam logic [PIX_W-1:0] BLACK = 8'd0;
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd110;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_MIN = 9'd3;

  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_COLUMNS   = 2'd1,
    REG_ROWS      = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } decision_t;

  typedef struct packed {
    logic             is_pixel;
    decision_t        dec;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } stage_t;

endpackage

// ===== rtl/ted_ram.sv =====
module ted_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ted_ctrl.sv =====
module ted_ctrl import ted_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              drain,
  input  logic [SIZE_W-1:0] cols,
  input  logic [SIZE_W-1:0] rows,
  output logic [COL_W-1:0]  col,
  output decision_t         dec
);

  logic [ROW_W-1:0] in_row, in_row_next, out_row, out_row_next, pos_row;
  logic [COL_W-1:0] in_col, in_col_next, out_col, out_col_next, pos_col;
  logic [SIZE_W-1:0] pos_row_inc, pos_col_inc, in_row_inc, in_col_inc;
  logic pix_emit, drain_emit;

  assign col = in_col;

  always_comb begin
    pix_emit = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_col != '0);
    drain_emit = (in_row == '0) && (in_col == '0) && !(out_row == '0 && out_col == '0);

    // a pixel beat's centre trails the input by one row and one pixel; a drain beat takes the pending output position
    if (drain) begin
      pos_row = out_row;
      pos_col = out_col;
    end else if (in_col != '0) begin
      pos_row = in_row - ROW_W'(1);
      pos_col = in_col - COL_W'(1);
    end else begin
      pos_row = in_row - ROW_W'(2);
      pos_col = COL_W'(cols - SIZE_W'(1));
    end

    pos_row_inc = SIZE_W'(pos_row) + SIZE_W'(1);
    pos_col_inc = SIZE_W'(pos_col) + SIZE_W'(1);
    in_row_inc = SIZE_W'(in_row) + SIZE_W'(1);
    in_col_inc = SIZE_W'(in_col) + SIZE_W'(1);

    dec.emit = drain ? drain_emit : pix_emit;
    dec.border = (pos_row == '0) || (pos_row_inc >= rows) ||
                 (pos_col == '0) || (pos_col_inc >= cols);
    dec.last = (pos_row_inc == rows) && (pos_col_inc == cols);

    if (pos_col_inc >= cols) begin
      out_col_next = '0;
      out_row_next = (pos_row_inc >= rows) ? '0 : ROW_W'(pos_row_inc);
    end else begin
      out_col_next = COL_W'(pos_col_inc);
      out_row_next = pos_row;
    end

    if (in_col_inc >= cols) begin
      in_col_next = '0;
      in_row_next = (in_row_inc >= rows) ? '0 : ROW_W'(in_row_inc);
    end else begin
      in_col_next = COL_W'(in_col_inc);
      in_row_next = in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (take) begin
      if (!drain) begin
        in_row <= in_row_next;
        in_col <= in_col_next;
      end
      if (dec.emit) begin
        out_row <= out_row_next;
        out_col <= out_col_next;
      end
    end
  end

endmodule

// ===== rtl/ted_window.sv =====
module ted_window import ted_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             is_pixel,
  input  logic             border,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] bot,
  input  logic [PIX_W-1:0] threshold,
  output logic [PIX_W-1:0] mark
);

  logic [PIX_W-1:0] win [3][3];
  logic [PIX_W-1:0] shifted [3][3];
  logic [PIX_W-1:0] view [3][3];
  logic [PIX_W-1:0] centre;
  logic any_above;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r][0] = win[r][1];
      shifted[r][1] = win[r][2];
    end
    shifted[0][2] = top;
    shifted[1][2] = mid;
    shifted[2][2] = bot;

    // a drain beat classifies against the window as it stands
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        view[r][c] = is_pixel ? shifted[r][c] : win[r][c];
      end
    end

    centre = view[1][1];
    any_above = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && view[r][c] > threshold) begin
          any_above = 1'b1;
        end
      end
    end

    if (border || centre > threshold) begin
      mark = WHITE;
    end else if (centre < threshold && any_above) begin
      mark = BLACK;
    end else begin
      mark = WHITE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (shift) begin
      win <= shifted;
    end
  end

endmodule

// ===== rtl/threshold_edge_detect_3x3.sv =====
// 3x3 threshold edge marker for 8-bit grey frames streamed in raster order.
// item channel: item_valid / item_stall with kind and pixel. kind 0 carries a
// pixel, kind 1 is a drain beat that releases one pending result after the
// frame's last pixel. result channel: result_valid / result_stall with
// edge_pixel (0 on an edge, 255 elsewhere) and last_of_frame.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// threshold, 1 columns per row, 2 rows per frame; sizes clamp to 3..256.
// results trail the pixels by one row plus one pixel; the first
// columns+1 pixels of a frame give no result.
// pipeline: the line stores are read at acceptance, when the beat also enters
// the window stage; when that stage steps, the window shifts, the stores are
// written back and the output register loads to offer the result.
// throughput is one beat per clock while item_stall stays low, set by the
// single read and single write port of each line store.
// a stalled result keeps the output register; beats that give no result still
// pass, the next beat with a result waits in the window stage and item_stall
// stays high until the stalled result goes.
// reset clears counters, window and the pipeline and restores threshold 110
// and a 256 x 256 frame; line store content is not cleared.
`include "threshold_edge_detect_3x3_macros.svh"

module threshold_edge_detect_3x3 import ted_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   kind,
  input  logic [PIX_W-1:0]       pixel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [PIX_W-1:0]       edge_pixel,
  output logic                   last_of_frame,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [PIX_W-1:0] threshold;
  logic [SIZE_W-1:0] columns_in_use, rows_in_use, cols, rows;

  logic take, drain, s1_step, ram_re, ram_we;
  logic [COL_W-1:0] rd_col;
  decision_t dec;
  stage_t s1;
  logic s1_valid;
  logic [PIX_W-1:0] older_rd, newer_rd, mark;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      columns_in_use <= SIZE_RESET;
      rows_in_use <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[PIX_W-1:0];
        REG_COLUMNS:   columns_in_use <= cfg_data[SIZE_W-1:0];
        REG_ROWS:      rows_in_use <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (columns_in_use < SIZE_MIN) cols = SIZE_MIN;
    else if (columns_in_use > SIZE_W'(MAX_COLUMNS)) cols = SIZE_W'(MAX_COLUMNS);
    else cols = columns_in_use;
    if (rows_in_use < SIZE_MIN) rows = SIZE_MIN;
    else if (rows_in_use > SIZE_W'(MAX_ROWS)) rows = SIZE_W'(MAX_ROWS);
    else rows = rows_in_use;
  end

  // window stage moves on unless its result has nowhere to go
  assign s1_step = s1_valid && (!s1.dec.emit || !result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_step;
  assign take = item_valid && !item_stall;
  assign drain = (kind == KIND_DRAIN);
  assign ram_re = take && !drain;
  assign ram_we = s1_step && s1.is_pixel;

  ted_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .drain (drain),
    .cols  (cols),
    .rows  (rows),
    .col   (rd_col),
    .dec   (dec)
  );

  ted_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLUMNS)) u_older (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.col),
    .wdata (newer_rd),
    .re    (ram_re),
    .raddr (rd_col),
    .rdata (older_rd)
  );

  ted_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLUMNS)) u_newer (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.col),
    .wdata (s1.pixel),
    .re    (ram_re),
    .raddr (rd_col),
    .rdata (newer_rd)
  );

  ted_window u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (ram_we),
    .is_pixel  (s1.is_pixel),
    .border    (s1.dec.border),
    .top       (older_rd),
    .mid       (newer_rd),
    .bot       (s1.pixel),
    .threshold (threshold),
    .mark      (mark)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.is_pixel <= !drain;
      s1.dec <= dec;
      s1.col <= rd_col;
      s1.pixel <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_step && s1.dec.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1.dec.emit) begin
      edge_pixel <= mark;
      last_of_frame <= s1.dec.last;
    end
  end

  // consecutive pixels never share a column, so no forwarding is needed
  `TED_ASSERT(a_no_rw_collision, clk, rst, !(ram_re && ram_we && rd_col == s1.col))
  `TED_ASSERT_NEXT(a_emit_lands, clk, rst, s1_step && s1.dec.emit, result_valid)
  `TED_ASSERT(a_last_is_white, clk, rst, result_valid && last_of_frame |-> edge_pixel == WHITE)

endmodule
